FILE: rtl/cascaded_indirect_target_predictor_top_assert.svh
// Assertion macros used by the predictor top level.
`ifndef CASCADED_INDIRECT_TARGET_PREDICTOR_TOP_ASSERT_SVH
`define CASCADED_INDIRECT_TARGET_PREDICTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define CITP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define CITP_ASSERT(label, clk, rst_n, prop, msg)
`define CITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/citp_pkg.sv
// Types and constants of the cascaded indirect target predictor.
package citp_pkg;

    localparam int PC_W      = 64;
    localparam int HIST_W    = 32;
    localparam int TAG_W     = 32;
    localparam int SHIFT_W   = 5;
    localparam int IDX_MAX   = 16;
    localparam int EXC_W     = TAG_W + PC_W;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd4;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_PREDICT = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_PUSH    = 2'd2,
        CMD_FIX     = 2'd3
    } cmd_t;

    // Table read request, issued when a request is accepted.
    typedef struct packed {
        logic               en;
        logic [IDX_MAX-1:0] flt_idx;
        logic [IDX_MAX-1:0] exc_idx;
    } citp_rd_t;

    // Table write request, issued when an update leaves the lookup stage.
    typedef struct packed {
        logic               flt_we;
        logic [IDX_MAX-1:0] flt_idx;
        logic [PC_W-1:0]    flt_data;
        logic               exc_we;
        logic [IDX_MAX-1:0] exc_idx;
        logic [TAG_W-1:0]   exc_tag;
        logic [PC_W-1:0]    exc_data;
    } citp_wr_t;

endpackage

FILE: rtl/citp_tables.sv
// Filter and exception tables with reset clearing sweep and write forwarding.
module citp_tables #(
    parameter int FI = 10,
    parameter int EI = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  citp_pkg::citp_rd_t         rd,
    input  citp_pkg::citp_wr_t         wr,
    input  logic [FI-1:0]              cur_flt_idx,
    input  logic [EI-1:0]              cur_exc_idx,
    output logic                       clearing,
    output logic [citp_pkg::PC_W-1:0]  flt_target,
    output logic [citp_pkg::TAG_W-1:0] exc_tag,
    output logic [citp_pkg::PC_W-1:0]  exc_target
);
    import citp_pkg::*;

    localparam int FDEPTH   = 1 << FI;
    localparam int EDEPTH   = 1 << EI;
    localparam int CLR_BITS = (FI > EI) ? FI : EI;

    logic [PC_W-1:0]  flt_mem [FDEPTH];
    logic [EXC_W-1:0] exc_mem [EDEPTH];

    logic [PC_W-1:0]     flt_rd_reg;
    logic [EXC_W-1:0]    exc_rd_reg;
    logic                clearing_reg;
    logic [CLR_BITS-1:0] clr_cnt_reg;

    logic                fwd_flt_valid_reg;
    logic [FI-1:0]       fwd_flt_idx_reg;
    logic [PC_W-1:0]     fwd_flt_data_reg;
    logic                fwd_exc_valid_reg;
    logic [EI-1:0]       fwd_exc_idx_reg;
    logic [EXC_W-1:0]    fwd_exc_data_reg;

    logic [EXC_W-1:0]    exc_entry;

    // Clearing sweep: one entry of each table per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Filter table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            flt_mem[clr_cnt_reg[FI-1:0]] <= '0;
        end
        else if (wr.flt_we)
        begin
            flt_mem[wr.flt_idx[FI-1:0]] <= wr.flt_data;
        end
        if (rd.en)
        begin
            flt_rd_reg <= flt_mem[rd.flt_idx[FI-1:0]];
        end
    end

    // Exception table: tag and target stored together in one entry.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            exc_mem[clr_cnt_reg[EI-1:0]] <= '0;
        end
        else if (wr.exc_we)
        begin
            exc_mem[wr.exc_idx[EI-1:0]] <= {wr.exc_tag, wr.exc_data};
        end
        if (rd.en)
        begin
            exc_rd_reg <= exc_mem[rd.exc_idx[EI-1:0]];
        end
    end

    // Last write to each table, to cover a read that raced the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_flt_valid_reg <= 1'b0;
            fwd_exc_valid_reg <= 1'b0;
        end
        else if (clearing_reg)
        begin
            fwd_flt_valid_reg <= 1'b0;
            fwd_exc_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.flt_we)
            begin
                fwd_flt_valid_reg <= 1'b1;
            end
            if (wr.exc_we)
            begin
                fwd_exc_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.flt_we)
        begin
            fwd_flt_idx_reg  <= wr.flt_idx[FI-1:0];
            fwd_flt_data_reg <= wr.flt_data;
        end
        if (wr.exc_we)
        begin
            fwd_exc_idx_reg  <= wr.exc_idx[EI-1:0];
            fwd_exc_data_reg <= {wr.exc_tag, wr.exc_data};
        end
    end

    // Read data as seen by the request now in the lookup stage.
    always_comb
    begin
        flt_target = (fwd_flt_valid_reg && (fwd_flt_idx_reg == cur_flt_idx))
                   ? fwd_flt_data_reg : flt_rd_reg;
        exc_entry  = (fwd_exc_valid_reg && (fwd_exc_idx_reg == cur_exc_idx))
                   ? fwd_exc_data_reg : exc_rd_reg;
    end

    assign exc_tag    = exc_entry[EXC_W-1:PC_W];
    assign exc_target = exc_entry[PC_W-1:0];
    assign clearing   = clearing_reg;

endmodule

FILE: rtl/cascaded_indirect_target_predictor_top.sv
// A request accepted into the lookup stage has its result registered in the output register when it advances.
// Throughput: one request per cycle unless the output stalls; the table read is registered at accept and the
// lookup and tag compare happen in the following cycle, the table write when the request leaves that stage.
// Reset: after rst_n is released the tables are cleared in a sweep of
// max(2**FILTER_INDEX_BITS, 2**EXCEPTION_INDEX_BITS) cycles while in_stall is high.
`include "cascaded_indirect_target_predictor_top_assert.svh"

module cascaded_indirect_target_predictor_top #(
    parameter int FILTER_INDEX_BITS    = 10,
    parameter int EXCEPTION_INDEX_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [citp_pkg::SHIFT_W-1:0] history_shift,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic [citp_pkg::PC_W-1:0]    branch_pc,
    input  logic [citp_pkg::HIST_W-1:0]  path_history,
    input  logic [citp_pkg::PC_W-1:0]    actual_target,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [citp_pkg::PC_W-1:0]    predicted_target,
    output logic                         exception_hit,
    output logic [citp_pkg::HIST_W-1:0]  next_history
);
    import citp_pkg::*;

    localparam int FI = FILTER_INDEX_BITS;
    localparam int EI = EXCEPTION_INDEX_BITS;

    logic [SHIFT_W-1:0] shift_reg;

    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic [TAG_W-1:0]   s1_tag_reg;
    logic [PC_W-1:0]    s1_target_reg;
    logic [HIST_W-1:0]  s1_hist_reg;
    logic [FI-1:0]      s1_flt_idx_reg;
    logic [EI-1:0]      s1_exc_idx_reg;

    logic               out_valid_reg;
    logic [PC_W-1:0]    out_pred_reg;
    logic               out_hit_reg;
    logic [HIST_W-1:0]  out_hist_reg;

    logic               accept;
    logic               s1_adv;
    logic               clearing;
    logic [31:0]        p_word;
    logic [31:0]        q_word;
    logic [31:0]        flt_mix;
    logic [31:0]        hist_mix;
    logic [31:0]        exc_mix;
    logic [FI-1:0]      in_flt_idx;
    logic [EI-1:0]      in_exc_idx;
    citp_rd_t           rd;
    citp_wr_t           wr;

    logic [PC_W-1:0]    flt_target;
    logic [TAG_W-1:0]   exc_tag;
    logic [PC_W-1:0]    exc_target;
    logic               hit;
    logic               lookup;
    logic               flt_wrong;
    logic [7:0]         hist_byte;
    logic [PC_W-1:0]    pred_next;
    logic               hit_next;
    logic [HIST_W-1:0]  hist_next;

    // Configuration register; the user must write it only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            shift_reg <= history_shift;
        end
    end

    // Handshake of the input and the lookup stage.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;

    // Index hashes, computed on the incoming request.
    always_comb
    begin
        p_word   = branch_pc[33:2];
        q_word   = branch_pc[31:0];
        flt_mix  = p_word ^ (p_word >> FI) ^ (p_word >> (2 * EI));
        hist_mix = {24'd0, path_history[7:0]}
                 ^ ({24'd0, path_history[15:8]} << shift_reg)
                 ^ ({24'd0, path_history[23:16]} << {shift_reg, 1'b0});
        exc_mix  = q_word ^ (q_word >> EI) ^ (q_word >> (2 * EI)) ^ hist_mix;
    end

    assign in_flt_idx = flt_mix[FI-1:0];
    assign in_exc_idx = exc_mix[EI-1:0];

    assign rd.en      = accept;
    assign rd.flt_idx = IDX_MAX'(in_flt_idx);
    assign rd.exc_idx = IDX_MAX'(in_exc_idx);

    // Lookup stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg     <= cmd_t'(command);
            s1_tag_reg     <= p_word;
            s1_target_reg  <= actual_target;
            s1_hist_reg    <= path_history;
            s1_flt_idx_reg <= in_flt_idx;
            s1_exc_idx_reg <= in_exc_idx;
        end
    end

    citp_tables #(
        .FI(FI),
        .EI(EI)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (rd),
        .wr         (wr),
        .cur_flt_idx(s1_flt_idx_reg),
        .cur_exc_idx(s1_exc_idx_reg),
        .clearing   (clearing),
        .flt_target (flt_target),
        .exc_tag    (exc_tag),
        .exc_target (exc_target)
    );

    // Prediction and table update decision.
    assign hit       = (exc_tag == s1_tag_reg);
    assign lookup    = (s1_cmd_reg == CMD_PREDICT) || (s1_cmd_reg == CMD_UPDATE);
    assign flt_wrong = (flt_target != s1_target_reg);

    always_comb
    begin
        wr.flt_we   = s1_adv && (s1_cmd_reg == CMD_UPDATE) && !hit && flt_wrong;
        wr.exc_we   = s1_adv && (s1_cmd_reg == CMD_UPDATE) && (hit || flt_wrong);
        wr.flt_idx  = IDX_MAX'(s1_flt_idx_reg);
        wr.flt_data = s1_target_reg;
        wr.exc_idx  = IDX_MAX'(s1_exc_idx_reg);
        wr.exc_tag  = s1_tag_reg;
        wr.exc_data = s1_target_reg;
    end

    // Result fields; history byte folds two bytes of the word-aligned target.
    assign hist_byte = s1_target_reg[9:2] ^ s1_target_reg[17:10];

    always_comb
    begin
        pred_next = lookup ? (hit ? exc_target : flt_target) : '0;
        hit_next  = lookup && hit;
        case (s1_cmd_reg)
            CMD_PUSH: hist_next = {s1_hist_reg[23:0], hist_byte};
            CMD_FIX:  hist_next = {s1_hist_reg[31:8], hist_byte};
            default:  hist_next = s1_hist_reg;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pred_reg <= pred_next;
            out_hit_reg  <= hit_next;
            out_hist_reg <= hist_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign predicted_target = out_pred_reg;
    assign exception_hit    = out_hit_reg;
    assign next_history     = out_hist_reg;

    // Checks on the lookup stage and table writes.
    `CITP_ASSERT(a_no_request_while_clearing, clk, rst_n, clearing |-> !s1_valid_reg, "request in lookup stage during clearing sweep")
    `CITP_ASSERT(a_history_cmd_no_write, clk, rst_n, (s1_valid_reg && (s1_cmd_reg == CMD_PUSH || s1_cmd_reg == CMD_FIX)) |-> (!wr.flt_we && !wr.exc_we), "history command wrote a table")
    `CITP_ASSERT(a_filter_write_allocates, clk, rst_n, wr.flt_we |-> wr.exc_we, "filter write without exception allocation")
    `CITP_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, s1_adv, out_valid_reg, "advanced request did not reach output register")
    `CITP_ASSERT_NEXT(a_held_request_stable, clk, rst_n, (s1_valid_reg && !s1_adv), (s1_valid_reg && $stable(s1_tag_reg)), "held lookup request changed")

endmodule

FILE: sim/tb_top.sv
// Testbench for the cascaded indirect target predictor: prediction scoreboard, drivers, checks.
`timescale 1ns / 100ps

module tb_top;
    import citp_pkg::*;

    localparam int FLT_BITS         = 10;
    localparam int EXC_BITS         = 10;
    localparam int FLT_DEPTH        = 1 << FLT_BITS;
    localparam int EXC_DEPTH        = 1 << EXC_BITS;
    localparam int PHASE_ITEMS      = 165;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 4;
    localparam longint RUN_LIMIT_NS = 10_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SHIFT_W-1:0]   history_shift;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           command;
    logic [PC_W-1:0]      branch_pc;
    logic [HIST_W-1:0]    path_history;
    logic [PC_W-1:0]      actual_target;
    logic                 out_valid;
    logic                 out_stall;
    logic [PC_W-1:0]      predicted_target;
    logic                 exception_hit;
    logic [HIST_W-1:0]    next_history;

    // Handshake between the stimulus and the result sink.
    bit                   burst_mode;
    bit                   long_hold_req;

    // Address, history and target pools, so that branches recur and hit the tables.
    logic [PC_W-1:0]      pc_pool [16];
    logic [HIST_W-1:0]    hist_pool [8];
    logic [PC_W-1:0]      tgt_pool [8];

    typedef struct {
        logic [PC_W-1:0]   target;
        logic              hit;
        logic [HIST_W-1:0] history;
    } lookup_result_t;

    // Mirror of the predictor tables and queue of predictions still owed by the block.
    class target_scoreboard;
        logic [PC_W-1:0]    filter_tgt [FLT_DEPTH];
        logic [PC_W-1:0]    exc_tgt [EXC_DEPTH];
        logic [TAG_W-1:0]   exc_tag [EXC_DEPTH];
        logic [SHIFT_W-1:0] shift_amt;
        lookup_result_t     pending_q [$];
        int                 failures;

        function new();
            foreach (filter_tgt[i]) filter_tgt[i] = '0;
            foreach (exc_tgt[i]) exc_tgt[i] = '0;
            foreach (exc_tag[i]) exc_tag[i] = '0;
            shift_amt = SHIFT_RESET;
            failures = 0;
        endfunction

        function void set_shift(logic [SHIFT_W-1:0] v);
            shift_amt = v;
        endfunction

        // Filter slot: fold of the word-aligned branch address.
        function logic [FLT_BITS-1:0] filter_slot(logic [PC_W-1:0] pc);
            logic [31:0] p;
            logic [31:0] x;
            p = pc[33:2];
            x = p ^ (p >> FLT_BITS) ^ (p >> (2 * EXC_BITS));
            return x[FLT_BITS-1:0];
        endfunction

        // Exception slot: fold of the low address bits mixed with three history bytes.
        function logic [EXC_BITS-1:0] exception_slot(logic [PC_W-1:0] pc, logic [HIST_W-1:0] h);
            logic [31:0] q;
            logic [31:0] b1;
            logic [31:0] b2;
            logic [31:0] x;
            int unsigned s2;
            q = pc[31:0];
            b1 = {24'd0, h[15:8]};
            b2 = {24'd0, h[23:16]};
            s2 = 2 * shift_amt;
            // A shift of 32 or more clears the byte, as the 32-bit hash requires.
            x = q ^ (q >> EXC_BITS) ^ (q >> (2 * EXC_BITS)) ^ {24'd0, h[7:0]}
                ^ (b1 << shift_amt) ^ (b2 << s2);
            return x[EXC_BITS-1:0];
        endfunction

        function logic [7:0] target_byte(logic [PC_W-1:0] t);
            logic [PC_W-1:0] a;
            logic [PC_W-1:0] x;
            a = t >> 2;
            x = a ^ (a >> 8);
            return x[7:0];
        endfunction

        // Work out the result of one accepted request and apply its table writes.
        function void note_request(cmd_t c, logic [PC_W-1:0] pc, logic [HIST_W-1:0] h,
                                   logic [PC_W-1:0] t);
            lookup_result_t      r;
            logic [FLT_BITS-1:0] fi;
            logic [EXC_BITS-1:0] ei;
            logic [TAG_W-1:0]    tag;
            r.target = '0;
            r.hit = 1'b0;
            r.history = h;
            case (c)
                CMD_PREDICT, CMD_UPDATE:
                begin
                    fi = filter_slot(pc);
                    ei = exception_slot(pc, h);
                    tag = pc[33:2];
                    r.hit = (exc_tag[ei] == tag);
                    r.target = r.hit ? exc_tgt[ei] : filter_tgt[fi];
                    if (c == CMD_UPDATE)
                    begin
                        if (r.hit)
                        begin
                            exc_tgt[ei] = t;
                        end
                        else if (filter_tgt[fi] != t)
                        begin
                            filter_tgt[fi] = t;
                            exc_tag[ei] = tag;
                            exc_tgt[ei] = t;
                        end
                    end
                end
                CMD_PUSH:
                begin
                    r.history = {h[23:0], target_byte(t)};
                end
                default:
                begin
                    r.history = {h[31:8], target_byte(t)};
                end
            endcase
            pending_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest owed prediction.
        function void check_result(logic [PC_W-1:0] tgt, logic hit, logic [HIST_W-1:0] h);
            lookup_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("result with no request pending: predicted_target %h", tgt);
                failures++;
                return;
            end
            e = pending_q.pop_front();
            if (tgt !== e.target)
            begin
                $error("predicted_target: expected %h, actual %h", e.target, tgt);
                failures++;
            end
            if (hit !== e.hit)
            begin
                $error("exception_hit: expected %0b, actual %0b", e.hit, hit);
                failures++;
            end
            if (h !== e.history)
            begin
                $error("next_history: expected %h, actual %h", e.history, h);
                failures++;
            end
        endfunction
    endclass

    target_scoreboard sb = new();

    cascaded_indirect_target_predictor_top #(
        .FILTER_INDEX_BITS    (FLT_BITS),
        .EXCEPTION_INDEX_BITS (EXC_BITS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .history_shift    (history_shift),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .branch_pc        (branch_pc),
        .path_history     (path_history),
        .actual_target    (actual_target),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .predicted_target (predicted_target),
        .exception_hit    (exception_hit),
        .next_history     (next_history)
    );

    // Clock with a 20 ns period.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Idle cycles after a request: mostly none or a few, now and then a long pause.
    function automatic int sender_gap();
        int unsigned roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one request, hold it until accepted, then note it in the scoreboard.
    task automatic send_request(input cmd_t c, input logic [PC_W-1:0] pc,
                                input logic [HIST_W-1:0] h, input logic [PC_W-1:0] t);
        int gap;
        in_valid <= 1'b1;
        command <= c;
        branch_pc <= pc;
        path_history <= h;
        actual_target <= t;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(c, pc, h, t);
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random request: mostly recurring branches and targets, the rest free values.
    task automatic send_random_request();
        cmd_t            c;
        logic [PC_W-1:0] pc;
        logic [31:0]     h;
        logic [PC_W-1:0] t;
        int unsigned     roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            c = CMD_PREDICT;
        else if (roll < 75)
            c = CMD_UPDATE;
        else if (roll < 88)
            c = CMD_PUSH;
        else
            c = CMD_FIX;
        pc = ($urandom_range(0, 9) < 8) ? pc_pool[$urandom_range(0, 15)] : rand64();
        h = ($urandom_range(0, 9) < 8) ? hist_pool[$urandom_range(0, 7)] : $urandom();
        t = ($urandom_range(0, 9) < 8) ? tgt_pool[$urandom_range(0, 7)] : rand64();
        send_request(c, pc, h, t);
    endtask

    // Write the history shift register.
    task automatic write_shift(input logic [SHIFT_W-1:0] v);
        cfg_valid <= 1'b1;
        history_shift <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_shift(v);
    endtask

    // Stop offering requests and wait until every prediction has come back or DRAIN_LIMIT runs out.
    task automatic wait_idle();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Result sink: checks accepted results and stalls at random.
    initial
    begin : result_sink
        int run_len;
        run_len = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(predicted_target, exception_hit, next_history);
            if (long_hold_req)
            begin
                // Long hold-off so that the block fills and stalls its input.
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
                run_len = $urandom_range(1, 12);
            end
            else if (run_len == 0)
            begin
                if (burst_mode || $urandom_range(0, 9) < 6)
                begin
                    out_stall <= 1'b0;
                    run_len = $urandom_range(1, 12);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
                end
            end
            else
            begin
                run_len--;
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed requests, then random phases under several shift settings.
    initial
    begin : stimulus
        logic [SHIFT_W-1:0] shift_plan [6];
        logic [PC_W-1:0]    pc_a;
        logic [PC_W-1:0]    pc_tag0;
        logic [PC_W-1:0]    ones64;
        logic [31:0]        ones32;
        shift_plan = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd9};
        pc_a = 64'h1234_5678_9abc_def0;
        pc_tag0 = 64'hffff_fffc_0000_0003;
        ones64 = '1;
        ones32 = '1;
        burst_mode = 1'b0;
        long_hold_req = 1'b0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        history_shift <= '0;
        in_valid <= 1'b0;
        command <= CMD_PREDICT;
        branch_pc <= '0;
        path_history <= '0;
        actual_target <= '0;

        foreach (pc_pool[i]) pc_pool[i] = rand64();
        foreach (hist_pool[i]) hist_pool[i] = $urandom();
        foreach (tgt_pool[i]) tgt_pool[i] = rand64();
        // Branches whose tag is zero hit the cleared exception entries.
        pc_pool[0] = pc_tag0;
        pc_pool[1] = '0;
        pc_pool[2] = ones64;
        hist_pool[0] = '0;
        hist_pool[1] = ones32;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the reset shift setting.
        send_request(CMD_PREDICT, '0, '0, '0);
        send_request(CMD_PREDICT, pc_tag0, ones32, ones64);
        send_request(CMD_UPDATE, ones64, ones32, ones64);
        send_request(CMD_PREDICT, ones64, ones32, '0);
        send_request(CMD_UPDATE, ones64, ones32, '0);
        send_request(CMD_PREDICT, ones64, ones32, ones64);
        send_request(CMD_UPDATE, pc_a, 32'h00a5_5a3c, '0);
        send_request(CMD_UPDATE, pc_a, 32'h00a5_5a3c, 64'hdead_beef_0000_1000);
        send_request(CMD_PREDICT, pc_a, 32'h0012_3456, '0);
        send_request(CMD_PREDICT, pc_a, 32'h00a5_5a3c, '0);
        send_request(CMD_UPDATE, pc_a, 32'h0012_3456, 64'hdead_beef_0000_1000);
        send_request(CMD_PUSH, '0, '0, ones64);
        send_request(CMD_PUSH, ones64, ones32, '0);
        send_request(CMD_FIX, ones64, ones32, ones64);
        send_request(CMD_FIX, pc_a, 32'h1234_5678, 64'h0000_0000_0000_0ffc);
        send_request(CMD_UPDATE, '0, '0, 64'h8);
        send_request(CMD_PREDICT, '0, '0, '0);
        send_request(CMD_UPDATE, pc_tag0, ones32, 64'h5555_aaaa_5555_aaaa);
        send_request(CMD_PREDICT, pc_tag0, ones32, '0);
        wait_idle();

        // Random phases, one per shift setting, the extremes among them.
        for (int i = 0; i < 6; i++)
        begin
            write_shift((i == 5) ? 5'($urandom_range(0, 31)) : shift_plan[i]);
            if (i == 2)
            begin
                // Hold the output back while requests keep coming.
                long_hold_req = 1'b1;
                burst_mode = 1'b1;
                repeat (24) send_random_request();
                burst_mode = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Stretches with no idling on either side.
                if (n % 60 == 30)
                    burst_mode = 1'b1;
                else if (n % 60 == 45)
                    burst_mode = 1'b0;
                send_random_request();
            end
            burst_mode = 1'b0;
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_q.size() != 0)
        begin
            $error("%0d predictions never returned", sb.pending_q.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/citp_pkg.sv
rtl/citp_tables.sv
rtl/cascaded_indirect_target_predictor_top.sv
sim/tb_top.sv
